// ===== rtl/dnsdc_pkg.sv =====
// Shared package of the DNS name decompressor: function and status codes,
// size defaults, and the command and status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dnsdc_pkg;

   localparam int MSG_BYTES_DEF   = 512;
   localparam int MAX_HOPS_DEF    = 64;
   localparam int MAX_NAME_OCTETS = 255;
   localparam int LABEL_MAX       = 63;
   localparam int PTR_BYTES       = 2;

   localparam int ADDR_W = 9;
   localparam int LEN_W  = 10;

   // Request function codes.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PARSE = 1'b1;

   // Result status codes. The code for a missing length octet cannot occur,
   // because a pointer target is always checked against the message end.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_PTR_RANGE = 3'd1;
   localparam logic [2:0] ST_PTR_LOOP  = 3'd2;
   localparam logic [2:0] ST_LAB_BIG   = 3'd4;
   localparam logic [2:0] ST_LAB_PAST  = 3'd5;
   localparam logic [2:0] ST_NAME_LONG = 3'd6;
   localparam logic [2:0] ST_NO_ROOT   = 3'd7;

   typedef struct packed {
      logic       load_wr;
      logic       start;
      logic       rd_next;
      logic       lab_step;
      logic       ptr_step;
      logic       finish;
      logic [2:0] code;
   } cmd_type;

   typedef struct packed {
      logic start_past;
      logic is_ptr;
      logic lab_big;
      logic lab_past;
      logic name_long;
      logic is_root;
      logic walk_end;
      logic ptr_range;
      logic ptr_loop;
      logic out_busy;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/dnsdc_ctrl.sv =====
// Controller of the DNS name decompressor: one-hot state machine that
// sequences loads and the label walk. Depends on dnsdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dnsdc_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_func,
   output logic                     req_ready,
   input  wire dnsdc_pkg::stat_type stat,
   output dnsdc_pkg::cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD0  = 5'b00010,
      S_LAB  = 5'b00100,
      S_PTR  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] code_ff, code_in;

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.code  = code_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == dnsdc_pkg::FUNC_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  if (stat.start_past) begin
                     code_in  = dnsdc_pkg::ST_NO_ROOT;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_RD0;
                  end
               end
            end
         end
         S_RD0: begin
            state_in = S_LAB;
         end
         S_LAB: begin
            // The byte after the current one is fetched in case this is a pointer.
            cmd.rd_next = 1'b1;
            if (stat.is_ptr) begin
               state_in = S_PTR;
            end else begin
               cmd.lab_step = 1'b1;
               state_in     = S_FIN;
               if (stat.lab_big) begin
                  code_in = dnsdc_pkg::ST_LAB_BIG;
               end else if (stat.lab_past) begin
                  code_in = dnsdc_pkg::ST_LAB_PAST;
               end else if (stat.name_long) begin
                  code_in = dnsdc_pkg::ST_NAME_LONG;
               end else if (stat.is_root) begin
                  code_in = dnsdc_pkg::ST_OK;
               end else if (stat.walk_end) begin
                  code_in = dnsdc_pkg::ST_NO_ROOT;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_PTR: begin
            state_in = S_FIN;
            if (stat.ptr_range) begin
               code_in = dnsdc_pkg::ST_PTR_RANGE;
            end else if (stat.ptr_loop) begin
               code_in = dnsdc_pkg::ST_PTR_LOOP;
            end else begin
               cmd.ptr_step = 1'b1;
               state_in     = S_RD0;
            end
         end
         S_FIN: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= dnsdc_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dnsdc_datapath.sv =====
// Datapath of the DNS name decompressor: message store, walk registers,
// label and pointer checks, and the result register. Depends on dnsdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dnsdc_datapath #(
   parameter int MSG_BYTES = dnsdc_pkg::MSG_BYTES_DEF,
   parameter int MAX_HOPS  = dnsdc_pkg::MAX_HOPS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire [dnsdc_pkg::ADDR_W-1:0]    req_addr,
   input  wire [7:0]                      req_data_byte,
   input  wire [dnsdc_pkg::LEN_W-1:0]     req_msg_len,
   input  wire dnsdc_pkg::cmd_type        cmd,
   output dnsdc_pkg::stat_type            stat,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_consumed,
   output logic [7:0]                     rsp_name_len
);

   localparam int AW = $clog2(MSG_BYTES);
   localparam int HW = $clog2(MAX_HOPS + 1);
   localparam int LW = dnsdc_pkg::LEN_W;

   logic [7:0]    mem [MSG_BYTES];
   logic [7:0]    rd_data_ff;
   logic [7:0]    b0_ff;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] len_ff, len_in;
   logic [8:0]    consumed_ff, consumed_in;
   logic [8:0]    name_ff, name_in;
   logic [HW-1:0] hops_ff, hops_in;
   logic          before_ptr_ff, before_ptr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff;
   logic [7:0]    rsp_consumed_ff, rsp_name_len_ff;

   logic [LW-1:0]    len_clamp;
   logic [LW:0]      rd_pos;
   logic [AW+LW:0]   rd_wide;
   logic [AW+LW-2:0] wr_wide;
   logic [AW-1:0]    rd_idx, wr_idx;
   logic             wr_ok;
   logic [LW-1:0]    lab_p1;
   logic [LW:0]      new_pos;
   logic [9:0]       name_sum;
   logic [9:0]       consumed_lab;
   logic [13:0]      ptr_off;
   logic [7:0]       consumed_sat;

   // Message length clamped to the store size.
   assign len_clamp = (32'(req_msg_len) > MSG_BYTES) ? LW'(MSG_BYTES) : req_msg_len;

   assign rd_pos  = cmd.rd_next ? ({1'b0, pos_ff} + 1'b1) : {1'b0, pos_ff};
   assign rd_wide = {{AW{1'b0}}, rd_pos};
   assign rd_idx  = rd_wide[AW-1:0];
   assign wr_wide = {{(AW + LW - 1 - dnsdc_pkg::ADDR_W){1'b0}}, req_addr};
   assign wr_idx  = wr_wide[AW-1:0];
   assign wr_ok   = 32'(req_addr) < MSG_BYTES;

   always_ff @(posedge clock) begin
      if (cmd.load_wr && wr_ok) begin
         mem[wr_idx] <= req_data_byte;
      end
      rd_data_ff <= mem[rd_idx];
   end

   // Label checks on the byte at the current position.
   assign lab_p1       = {2'b00, rd_data_ff} + 1'b1;
   assign new_pos      = {1'b0, pos_ff} + {1'b0, lab_p1};
   assign name_sum     = {1'b0, name_ff} + lab_p1;
   assign consumed_lab = {1'b0, consumed_ff} + lab_p1;
   assign ptr_off      = {b0_ff[5:0], rd_data_ff};

   always_comb begin
      stat            = '0;
      stat.start_past = {1'b0, req_addr} >= len_clamp;
      stat.is_ptr     = (({1'b0, pos_ff} + 1'b1) < {1'b0, len_ff})
                        && (rd_data_ff[7:6] == 2'b11);
      stat.lab_big    = rd_data_ff > 8'(dnsdc_pkg::LABEL_MAX);
      stat.lab_past   = (len_ff - pos_ff) < lab_p1;
      stat.name_long  = name_sum > 10'(dnsdc_pkg::MAX_NAME_OCTETS);
      stat.is_root    = rd_data_ff == 8'd0;
      stat.walk_end   = new_pos >= {1'b0, len_ff};
      stat.ptr_range  = ptr_off >= {4'b0000, len_ff};
      stat.ptr_loop   = hops_ff >= HW'(MAX_HOPS);
      stat.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      pos_in        = pos_ff;
      len_in        = len_ff;
      consumed_in   = consumed_ff;
      name_in       = name_ff;
      hops_in       = hops_ff;
      before_ptr_in = before_ptr_ff;
      if (cmd.start) begin
         pos_in        = LW'(req_addr);
         len_in        = len_clamp;
         consumed_in   = '0;
         name_in       = '0;
         hops_in       = '0;
         before_ptr_in = 1'b1;
      end else if (cmd.lab_step) begin
         pos_in  = new_pos[LW-1:0];
         name_in = name_sum[8:0];
         if (before_ptr_ff) begin
            consumed_in = consumed_lab[8:0];
         end
      end else if (cmd.ptr_step) begin
         // The target lies below the message length, so it fits the position.
         pos_in        = ptr_off[LW-1:0];
         hops_in       = hops_ff + 1'b1;
         before_ptr_in = 1'b0;
         if (before_ptr_ff) begin
            consumed_in = consumed_ff + 9'(dnsdc_pkg::PTR_BYTES);
         end
      end
   end

   assign consumed_sat = consumed_ff[8] ? 8'hFF : consumed_ff[7:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      len_ff        <= len_in;
      consumed_ff   <= consumed_in;
      name_ff       <= name_in;
      hops_ff       <= hops_in;
      before_ptr_ff <= before_ptr_in;
      if (cmd.rd_next) begin
         b0_ff <= rd_data_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff <= cmd.code;
         if (cmd.code == dnsdc_pkg::ST_OK) begin
            rsp_consumed_ff <= consumed_sat;
            rsp_name_len_ff <= name_ff[7:0];
         end else begin
            rsp_consumed_ff <= '0;
            rsp_name_len_ff <= '0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_consumed = rsp_consumed_ff;
   assign rsp_name_len = rsp_name_len_ff;

endmodule
`default_nettype wire

// ===== rtl/dns_name_decompressor_core.sv =====
// A load is taken while idle and ready stays high, so loads run back to back.
// A parse is accepted in S_IDLE, steps through S_RD0 and S_LAB for each label, adds S_PTR
// for each pointer, and ends in S_FIN, which waits while an earlier result still waits: the
// walk reads the message store one byte per cycle through its single registered read port.
// Throughput: one parse at a time; ready is low from parse start until the result is queued.
// Reset is synchronous and active high; it clears the controller and the result valid.
`timescale 1ns / 1ps
`default_nettype none
module dns_name_decompressor_core #(
   parameter int MSG_BYTES = dnsdc_pkg::MSG_BYTES_DEF,
   parameter int MAX_HOPS  = dnsdc_pkg::MAX_HOPS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         req_func,
   input  wire [dnsdc_pkg::ADDR_W-1:0] req_addr,
   input  wire [7:0]                   req_data_byte,
   input  wire [dnsdc_pkg::LEN_W-1:0]  req_msg_len,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [7:0]                  rsp_consumed,
   output logic [7:0]                  rsp_name_len
);

   // The controller issues one command per cycle; the datapath answers with the
   // outcome of its label and pointer checks on the byte it has just read.
   // The message store keeps its contents over reset and must be loaded before use.
   dnsdc_pkg::cmd_type  cmd;
   dnsdc_pkg::stat_type stat;

   // The controller decides whether an item is a load or a parse, and walks the
   // name one label or pointer at a time until a final status is known.
   dnsdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the message store and the walk state. Its result register
   // lets the next item in while a finished result still waits to be taken.
   dnsdc_datapath #(
      .MSG_BYTES (MSG_BYTES),
      .MAX_HOPS  (MAX_HOPS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_addr      (req_addr),
      .req_data_byte (req_data_byte),
      .req_msg_len   (req_msg_len),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_consumed  (rsp_consumed),
      .rsp_name_len  (rsp_name_len)
   );

endmodule
`default_nettype wire
